FILE: rtl/core/sphp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sphp_pkg;

  localparam int NUM_SLABS_DEF   = 16;
  localparam int TIME_BITS_DEF   = 21;
  localparam int CHARGE_BITS_DEF = 12;
  localparam int FIFO_DEPTH_DEF  = 2;

  localparam int ROW_BITS = 5;
  localparam int NUM_ROWS = 32;

  localparam int TICK_W = 20;
  localparam logic [TICK_W-1:0] TICK_RESET = 20'd26214;

  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] ADDR_TICK_PERIOD = 2'd0;

  localparam int TICKS_W = 22;
  localparam int MEAN_W  = 30;
  localparam int QOUT_W  = 12;
  localparam int QSUM_W  = 13;
  localparam int QPROD_W = 11;

  localparam logic signed [33:0] TICKS_MAX = 34'sd2097151;
  localparam logic signed [33:0] TICKS_MIN = -34'sd2097151;
  localparam logic signed [43:0] MEAN_MAX  = 44'sd536870911;
  localparam logic signed [43:0] MEAN_MIN  = -44'sd536870912;
  localparam logic signed [43:0] MEAN_HALF = 44'sd4096;
  localparam int MEAN_SHIFT = 13;

  localparam logic [16:0] QOUT_MAX  = 17'd4095;
  localparam logic [16:0] QSUM_MAX  = 17'd8191;
  localparam logic [16:0] QPROD_MAX = 17'd2047;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CMP,
    F_ARM,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_MUL,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sphp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sphp_in_if #(
  parameter int TIME_BITS   = sphp_pkg::TIME_BITS_DEF,
  parameter int CHARGE_BITS = sphp_pkg::CHARGE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             station;
  logic                   plane;
  logic [3:0]             slab;
  logic                   side;
  logic [TIME_BITS-1:0]   leading_time;
  logic [TIME_BITS-1:0]   trigger_time;
  logic [CHARGE_BITS-1:0] charge;
  logic                   last_digit;

  modport source (
    output valid, station, plane, slab, side, leading_time, trigger_time, charge,
    output last_digit,
    input  ready
  );

  modport sink (
    input  valid, station, plane, slab, side, leading_time, trigger_time, charge,
    input  last_digit,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/sphp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sphp_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              hit_station;
  logic                                    hit_plane;
  logic [3:0]                              hit_slab;
  logic signed [sphp_pkg::TICKS_W-1:0]     side0_ticks;
  logic signed [sphp_pkg::TICKS_W-1:0]     side1_ticks;
  logic signed [sphp_pkg::MEAN_W-1:0]      mean_time;
  logic [sphp_pkg::QOUT_W-1:0]             side0_charge;
  logic [sphp_pkg::QOUT_W-1:0]             side1_charge;
  logic [sphp_pkg::QSUM_W-1:0]             charge_sum;
  logic [sphp_pkg::QPROD_W-1:0]            charge_product;
  logic                                    last_hit;

  modport source (
    output valid, hit_station, hit_plane, hit_slab, side0_ticks, side1_ticks, mean_time,
    output side0_charge, side1_charge, charge_sum, charge_product, last_hit,
    input  ready
  );

  modport sink (
    input  valid, hit_station, hit_plane, hit_slab, side0_ticks, side1_ticks, mean_time,
    input  side0_charge, side1_charge, charge_sum, charge_product, last_hit,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/sphp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sphp_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = sphp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output sphp_pkg::fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = slots_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  a_push_pop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && pop |=> count_r == $past(count_r))
    else $error("Queue fill level changed on a simultaneous push and pop.");

endmodule

`default_nettype wire

FILE: rtl/core/sphp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sphp_front #(
  parameter int NUM_SLABS   = sphp_pkg::NUM_SLABS_DEF,
  parameter int TIME_BITS   = sphp_pkg::TIME_BITS_DEF,
  parameter int CHARGE_BITS = sphp_pkg::CHARGE_BITS_DEF,
  localparam int ENTRY_W    = 2 * TIME_BITS + CHARGE_BITS,
  localparam int REC_W      = 3 + sphp_pkg::ROW_BITS + 2 * ENTRY_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sphp_in_if.sink              in_ch,
  input  sphp_pkg::fifo_stat_t fifo_stat,
  output logic                 fifo_push,
  output logic [REC_W-1:0]     fifo_wdata
);

  localparam int ROW_BITS = sphp_pkg::ROW_BITS;
  localparam int NUM_ROWS = sphp_pkg::NUM_ROWS;

  logic [ENTRY_W-1:0] mem0 [NUM_ROWS];
  logic [ENTRY_W-1:0] mem1 [NUM_ROWS];
  logic [ENTRY_W-1:0] rd0_r, rd1_r;

  sphp_pkg::front_state_t state_r, state_nxt;
  logic [NUM_ROWS-1:0] valid0_r, valid0_nxt;
  logic [NUM_ROWS-1:0] valid1_r, valid1_nxt;
  logic [NUM_ROWS-1:0] mask_r, mask_nxt, mask_left;
  logic [ROW_BITS-1:0] idx_r, idx_nxt;
  logic [1:0]          station_r, station_nxt;
  logic [ROW_BITS-1:0] rd_addr;

  logic [ROW_BITS-1:0] dg_row_r;
  logic                dg_side_r;
  logic                dg_last_r;
  logic                dg_keep_r;
  logic [ENTRY_W-1:0]  dg_entry_r;

  logic                in_acc;
  logic [ENTRY_W-1:0]  stored;
  logic                stored_valid;
  logic                replace;
  logic                wr0, wr1;
  logic                push_last;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign rd_addr      = (state_r == sphp_pkg::F_IDLE) ? {in_ch.plane, in_ch.slab} : idx_r;
  assign stored       = dg_side_r ? rd1_r : rd0_r;
  assign stored_valid = dg_side_r ? valid1_r[dg_row_r] : valid0_r[dg_row_r];
  assign replace      = dg_keep_r && (!stored_valid ||
                        (dg_entry_r[ENTRY_W-1 -: TIME_BITS] < stored[ENTRY_W-1 -: TIME_BITS]));
  assign wr0          = (state_r == sphp_pkg::F_CMP) && replace && !dg_side_r;
  assign wr1          = (state_r == sphp_pkg::F_CMP) && replace && dg_side_r;

  always_comb begin
    mask_left         = mask_r;
    mask_left[idx_r]  = 1'b0;
  end

  assign push_last  = (mask_left == '0);
  assign fifo_wdata = {station_r, idx_r, push_last, rd0_r, rd1_r};

  always_comb begin
    state_nxt   = state_r;
    valid0_nxt  = valid0_r;
    valid1_nxt  = valid1_r;
    mask_nxt    = mask_r;
    idx_nxt     = idx_r;
    station_nxt = station_r;
    in_ch.ready = 1'b0;
    fifo_push   = 1'b0;
    unique case (state_r)
      sphp_pkg::F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          station_nxt = in_ch.station;
          state_nxt   = sphp_pkg::F_CMP;
        end
      end
      sphp_pkg::F_CMP: begin
        if (wr0) begin
          valid0_nxt[dg_row_r] = 1'b1;
        end
        if (wr1) begin
          valid1_nxt[dg_row_r] = 1'b1;
        end
        state_nxt = dg_last_r ? sphp_pkg::F_ARM : sphp_pkg::F_IDLE;
      end
      sphp_pkg::F_ARM: begin
        mask_nxt   = valid0_r & valid1_r;
        valid0_nxt = '0;
        valid1_nxt = '0;
        idx_nxt    = '0;
        state_nxt  = sphp_pkg::F_SCAN;
      end
      sphp_pkg::F_SCAN: begin
        if (mask_r == '0) begin
          state_nxt = sphp_pkg::F_IDLE;
        end else if (mask_r[idx_r]) begin
          state_nxt = sphp_pkg::F_PUSH;
        end else begin
          idx_nxt = idx_r + ROW_BITS'(1);
        end
      end
      sphp_pkg::F_PUSH: begin
        if (!fifo_stat.full) begin
          fifo_push = 1'b1;
          mask_nxt  = mask_left;
          idx_nxt   = idx_r + ROW_BITS'(1);
          state_nxt = sphp_pkg::F_SCAN;
        end
      end
      default: state_nxt = sphp_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sphp_pkg::F_IDLE;
      valid0_r  <= '0;
      valid1_r  <= '0;
      mask_r    <= '0;
      idx_r     <= '0;
      station_r <= '0;
    end else begin
      state_r   <= state_nxt;
      valid0_r  <= valid0_nxt;
      valid1_r  <= valid1_nxt;
      mask_r    <= mask_nxt;
      idx_r     <= idx_nxt;
      station_r <= station_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dg_row_r   <= {in_ch.plane, in_ch.slab};
      dg_side_r  <= in_ch.side;
      dg_last_r  <= in_ch.last_digit;
      dg_keep_r  <= ({1'b0, in_ch.slab} < 5'(NUM_SLABS));
      dg_entry_r <= {in_ch.leading_time, in_ch.trigger_time, in_ch.charge};
    end
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      mem0[dg_row_r] <= dg_entry_r;
    end
    if (wr1) begin
      mem1[dg_row_r] <= dg_entry_r;
    end
    rd0_r <= mem0[rd_addr];
    rd1_r <= mem1[rd_addr];
  end

  a_marks_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_digit |=> ##2 (valid0_r == '0 && valid1_r == '0))
    else $error("Channel marks not cleared after the closing digit.");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push && push_last |=> (state_r == sphp_pkg::F_SCAN && mask_r == '0))
    else $error("Final pair flagged while paired slabs remain.");

endmodule

`default_nettype wire

FILE: rtl/core/sphp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sphp_back #(
  parameter int TIME_BITS   = sphp_pkg::TIME_BITS_DEF,
  parameter int CHARGE_BITS = sphp_pkg::CHARGE_BITS_DEF,
  localparam int ENTRY_W    = 2 * TIME_BITS + CHARGE_BITS,
  localparam int REC_W      = 3 + sphp_pkg::ROW_BITS + 2 * ENTRY_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sphp_pkg::TICK_W-1:0]   tick_period,
  input  sphp_pkg::fifo_stat_t          fifo_stat,
  output logic                          fifo_pop,
  input  logic [REC_W-1:0]              fifo_rdata,
  sphp_out_if.source                    out_ch
);

  localparam int CB     = CHARGE_BITS;
  localparam int QS_W   = CB + 1;
  localparam int QP_W   = 2 * CB;
  localparam int CNT_W  = $clog2(CB + 1);
  localparam int TW     = sphp_pkg::TICKS_W;

  sphp_pkg::back_state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              load_out;

  logic [REC_W-1:0]      rec_r;
  logic signed [TW-1:0]  t0_r, t1_r;
  logic [QS_W-1:0]       qsum_r;
  logic [QP_W-1:0]       qprod_r;
  logic signed [43:0]    mprod_r;
  logic [CB:0]           rem_r;
  logic [CB-1:0]         dvd_r;
  logic [CB-1:0]         quo_r;

  logic [1:0]                  o_station_r;
  logic                        o_plane_r;
  logic [3:0]                  o_slab_r;
  logic signed [TW-1:0]        o_t0_r, o_t1_r;
  logic signed [sphp_pkg::MEAN_W-1:0] o_mean_r;
  logic [sphp_pkg::QOUT_W-1:0] o_q0_r, o_q1_r;
  logic [sphp_pkg::QSUM_W-1:0] o_qsum_r;
  logic [sphp_pkg::QPROD_W-1:0] o_qprod_r;
  logic                        o_last_r;

  logic [ENTRY_W-1:0]  e0, e1;
  logic [CB-1:0]       q0, q1;
  logic [CB+1:0]       sh, diff;
  logic                ge;
  logic [CB:0]         rem_step;
  logic signed [43:0]  mean_v, mean_q, mean_c;
  logic [16:0]         q0_x, q1_x, qsum_x, qprod_x;

  function automatic logic signed [sphp_pkg::TICKS_W-1:0] ticks_of(
    input logic [TIME_BITS-1:0] lead,
    input logic [TIME_BITS-1:0] trig
  );
    logic signed [33:0] d;
    d = $signed(34'(lead)) - $signed(34'(trig));
    if (d > sphp_pkg::TICKS_MAX) begin
      d = sphp_pkg::TICKS_MAX;
    end else if (d < sphp_pkg::TICKS_MIN) begin
      d = sphp_pkg::TICKS_MIN;
    end
    return d[sphp_pkg::TICKS_W-1:0];
  endfunction

  assign e0 = rec_r[2*ENTRY_W-1 -: ENTRY_W];
  assign e1 = rec_r[ENTRY_W-1:0];
  assign q0 = e0[CB-1:0];
  assign q1 = e1[CB-1:0];

  assign sh       = {rem_r, dvd_r[CB-1]};
  assign ge       = (sh >= {1'b0, qsum_r});
  assign diff     = sh - {1'b0, qsum_r};
  assign rem_step = ge ? diff[CB:0] : sh[CB:0];

  always_comb begin
    mean_v = mprod_r + sphp_pkg::MEAN_HALF;
    mean_q = mean_v >>> sphp_pkg::MEAN_SHIFT;
    if (mean_q > sphp_pkg::MEAN_MAX) begin
      mean_c = sphp_pkg::MEAN_MAX;
    end else if (mean_q < sphp_pkg::MEAN_MIN) begin
      mean_c = sphp_pkg::MEAN_MIN;
    end else begin
      mean_c = mean_q;
    end
  end

  assign q0_x    = 17'(q0);
  assign q1_x    = 17'(q1);
  assign qsum_x  = 17'(qsum_r);
  assign qprod_x = (qsum_r == '0) ? 17'd0 : 17'(quo_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    fifo_pop      = 1'b0;
    load_out      = 1'b0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      sphp_pkg::B_IDLE: begin
        if (!fifo_stat.empty) begin
          fifo_pop  = 1'b1;
          state_nxt = sphp_pkg::B_PREP;
        end
      end
      sphp_pkg::B_PREP: state_nxt = sphp_pkg::B_MUL;
      sphp_pkg::B_MUL: begin
        cnt_nxt   = CNT_W'(CB);
        state_nxt = sphp_pkg::B_DIV;
      end
      sphp_pkg::B_DIV: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = sphp_pkg::B_DONE;
        end
      end
      sphp_pkg::B_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sphp_pkg::B_IDLE;
        end
      end
      default: state_nxt = sphp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sphp_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      rec_r <= fifo_rdata;
    end
    if (state_r == sphp_pkg::B_PREP) begin
      t0_r    <= ticks_of(e0[ENTRY_W-1 -: TIME_BITS], e0[CB +: TIME_BITS]);
      t1_r    <= ticks_of(e1[ENTRY_W-1 -: TIME_BITS], e1[CB +: TIME_BITS]);
      qsum_r  <= QS_W'(q0) + QS_W'(q1);
      qprod_r <= QP_W'(q0) * QP_W'(q1);
    end
    if (state_r == sphp_pkg::B_MUL) begin
      mprod_r <= $signed({1'b0, tick_period}) *
                 ($signed({t0_r[TW-1], t0_r}) + $signed({t1_r[TW-1], t1_r}));
      rem_r   <= {1'b0, qprod_r[QP_W-1:CB]};
      dvd_r   <= qprod_r[CB-1:0];
    end
    if (state_r == sphp_pkg::B_DIV) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[CB-2:0], 1'b0};
      quo_r <= {quo_r[CB-2:0], ge};
    end
    if (load_out) begin
      o_station_r <= rec_r[REC_W-1 -: 2];
      o_plane_r   <= rec_r[REC_W-3];
      o_slab_r    <= rec_r[REC_W-4 -: 4];
      o_last_r    <= rec_r[2*ENTRY_W];
      o_t0_r      <= t0_r;
      o_t1_r      <= t1_r;
      o_mean_r    <= mean_c[sphp_pkg::MEAN_W-1:0];
      o_q0_r      <= (q0_x > sphp_pkg::QOUT_MAX) ? sphp_pkg::QOUT_MAX[11:0] : q0_x[11:0];
      o_q1_r      <= (q1_x > sphp_pkg::QOUT_MAX) ? sphp_pkg::QOUT_MAX[11:0] : q1_x[11:0];
      o_qsum_r    <= (qsum_x > sphp_pkg::QSUM_MAX) ? sphp_pkg::QSUM_MAX[12:0] : qsum_x[12:0];
      o_qprod_r   <= (qprod_x > sphp_pkg::QPROD_MAX) ? sphp_pkg::QPROD_MAX[10:0]
                                                     : qprod_x[10:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit_station    = o_station_r;
  assign out_ch.hit_plane      = o_plane_r;
  assign out_ch.hit_slab       = o_slab_r;
  assign out_ch.side0_ticks    = o_t0_r;
  assign out_ch.side1_ticks    = o_t1_r;
  assign out_ch.mean_time      = o_mean_r;
  assign out_ch.side0_charge   = o_q0_r;
  assign out_ch.side1_charge   = o_q1_r;
  assign out_ch.charge_sum     = o_qsum_r;
  assign out_ch.charge_product = o_qprod_r;
  assign out_ch.last_hit       = o_last_r;

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sphp_pkg::B_DIV && qsum_r != '0) |-> ({1'b0, rem_r} < {1'b0, qsum_r}))
    else $error("Divider remainder reached the divisor.");

endmodule

`default_nettype wire

FILE: rtl/core/slab_pmt_hit_pairing.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Each request carries
// in_ch    input      valid / ready       one tube digit of the current event
// out_ch   output     valid / ready       one paired slab hit
// APB      input      psel, penable       tick_period_q20 at byte address 0
//
// A digit is read from the channel memory, then compared and written.
// The closing digit adds the F_ARM state, then the walk scans each slab position up
// to the last paired slab, pushes each paired slab and ends with one final scan; no
// digit is taken during the walk.
// In the back end each hit passes PREP, MUL, the bit-serial divider (DIV) and DONE.
// Reset is synchronous; the channel marks clear at once and no clearing pass is run.
// A stalled output holds its hit while the queue fills, and a full queue holds the walk.
module slab_pmt_hit_pairing #(
  parameter int NUM_SLABS   = sphp_pkg::NUM_SLABS_DEF,
  parameter int TIME_BITS   = sphp_pkg::TIME_BITS_DEF,
  parameter int CHARGE_BITS = sphp_pkg::CHARGE_BITS_DEF,
  parameter int FIFO_DEPTH  = sphp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sphp_in_if.sink                      in_ch,
  sphp_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sphp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int ENTRY_W = 2 * TIME_BITS + CHARGE_BITS;
  localparam int REC_W   = 3 + sphp_pkg::ROW_BITS + 2 * ENTRY_W;

  logic [sphp_pkg::TICK_W-1:0] tick_r;
  logic                        cfg_wr;

  sphp_pkg::fifo_stat_t fifo_stat;
  logic                 fifo_push;
  logic                 fifo_pop;
  logic [REC_W-1:0]     fifo_wdata;
  logic [REC_W-1:0]     fifo_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == sphp_pkg::ADDR_TICK_PERIOD);
  assign prdata = (paddr == sphp_pkg::ADDR_TICK_PERIOD) ? 32'(tick_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= sphp_pkg::TICK_RESET;
    end else if (cfg_wr) begin
      tick_r <= pwdata[sphp_pkg::TICK_W-1:0];
    end
  end

  sphp_front #(
    .NUM_SLABS   (NUM_SLABS),
    .TIME_BITS   (TIME_BITS),
    .CHARGE_BITS (CHARGE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fifo_stat  (fifo_stat),
    .fifo_push  (fifo_push),
    .fifo_wdata (fifo_wdata)
  );

  sphp_fifo #(
    .WIDTH (REC_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .stat  (fifo_stat)
  );

  sphp_back #(
    .TIME_BITS   (TIME_BITS),
    .CHARGE_BITS (CHARGE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_period (tick_r),
    .fifo_stat   (fifo_stat),
    .fifo_pop    (fifo_pop),
    .fifo_rdata  (fifo_rdata),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
